/* rtl/mahct_pkg.sv */
// mahct_pkg: shared constants for the mac address chained hash table
// operation codes, field widths and parameter defaults
// no dependencies
`default_nettype none

package mahct_pkg;

  // parameter defaults
  localparam int unsigned POOL_NODES_DEF = 32;
  localparam int unsigned BUCKETS_DEF    = 16;

  // hash word: bytes 2..5 of the address
  localparam int unsigned HASH_BYTE_OFFSET = 2;
  localparam int unsigned HASH_BITS        = 32;
  localparam int unsigned HASH_LSB         = 8 * HASH_BYTE_OFFSET;

  // field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned BKT_W    = 4;
  localparam int unsigned NODE_W   = 5;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 16;

  // input beat layout
  localparam int unsigned FUNC_LSB = 0;
  localparam int unsigned MAC_LSB  = FUNC_LSB + FUNC_W;
  localparam int unsigned TAG_LSB  = MAC_LSB + MAC_W;

  // result beat layout
  localparam int unsigned HIT_BIT  = 0;
  localparam int unsigned BKT_LSB  = HIT_BIT + 1;
  localparam int unsigned NODE_LSB = BKT_LSB + BKT_W;
  localparam int unsigned FULL_BIT = NODE_LSB + NODE_W;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

endpackage

`default_nettype wire

/* rtl/mahct_ram.sv */
// mahct_ram: generic single write port, single read port ram
// registered read data, no reset on the array
// no dependencies
`default_nettype none

module mahct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/mahct_mod.sv */
// mahct_mod: remainder of the 32-bit hash word by the bucket count
// reciprocal multiply, quotient fix-up and back-multiply, one step after another for each word
// depends on mahct_pkg
`default_nettype none

module mahct_mod #(
  parameter int unsigned BUCKETS = mahct_pkg::BUCKETS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [mahct_pkg::HASH_BITS-1:0] word_i,
  output      logic                           busy_o,
  output      logic [$clog2(BUCKETS)-1:0]     rem_o
);

  localparam int unsigned HW  = mahct_pkg::HASH_BITS;
  localparam int unsigned BW  = $clog2(BUCKETS);
  localparam int unsigned QSH = BW - 1;
  // magic multiplier for unsigned division by the bucket count
  localparam logic [63:0] RECIP_W =
    ((((64'd1 << BW) - 64'(BUCKETS)) << HW) / 64'(BUCKETS)) + 64'd1;
  localparam logic [HW-1:0] RECIP   = RECIP_W[HW-1:0];
  localparam logic [HW-1:0] DIVISOR = HW'(BUCKETS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_QUO  = 2'd2;
  localparam logic [1:0] ST_REM  = 2'd3;

  logic [1:0]      stage_q, stage_d;
  logic [HW-1:0]   word_q, word_d;
  logic [HW-1:0]   hi_q, hi_d;
  logic [HW-1:0]   quo_q, quo_d;
  logic [BW-1:0]   rem_q, rem_d;
  logic [2*HW-1:0] prod;
  logic [HW-1:0]   fix;
  logic [HW-1:0]   back;
  logic [HW-1:0]   diff;

  // upper half of word times reciprocal
  assign prod = (2*HW)'(word_q) * (2*HW)'(RECIP);
  // quotient correction before the final shift
  assign fix  = hi_q + ((word_q - hi_q) >> 1);
  // remainder from the quotient
  assign back = quo_q * DIVISOR;
  assign diff = word_q - back;

  // stage sequencing
  always_comb begin
    stage_d = stage_q;
    word_d  = word_q;
    hi_d    = hi_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (start_i) begin
      stage_d = ST_MUL;
      word_d  = word_i;
    end else begin
      case (stage_q)
        ST_MUL: begin
          hi_d    = prod[2*HW-1:HW];
          stage_d = ST_QUO;
        end
        ST_QUO: begin
          quo_d   = fix >> QSH;
          stage_d = ST_REM;
        end
        ST_REM: begin
          rem_d   = diff[BW-1:0];
          stage_d = ST_IDLE;
        end
        default: begin
          stage_d = stage_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_IDLE;
    end else begin
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    hi_q   <= hi_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign busy_o = (stage_q != ST_IDLE);
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/mac_address_chained_hash_table.sv */
// mac_address_chained_hash_table: top level, sequencer, node pool and bucket rams
// depends on mahct_pkg, mahct_ram, mahct_mod
//
// channel   dir  beat fields (lsb first)
// s_axis    in   tdata: func[1:0], mac_addr[47:0], status_tag[7:0], zero pad to 64
// m_axis    out  tdata: hit, bucket_index[3:0], node_index[4:0], table_full, zero pad to 16
//
// lookup: accept the beat, run the remainder unit, take its remainder, read the bucket,
// read and compare each chain node, hand off the result. insert: as far as the bucket
// read, then a scan of up to POOL_NODES - 1 pool slots, a node write and, if the bucket
// had a chain, a link write; a zero tag skips to the result, as do clear and unknown codes.
// rst_ni empties the table at once through per-node and per-bucket valid bits.
// a stalled result sits in the output register; the next beat is taken meanwhile.
`default_nettype none

module mac_address_chained_hash_table #(
  parameter int unsigned POOL_NODES = mahct_pkg::POOL_NODES_DEF,
  parameter int unsigned BUCKETS    = mahct_pkg::BUCKETS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  // func[1:0], mac_addr[49:2], status_tag[57:50], zero [63:58]
  input  wire logic [mahct_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // hit[0], bucket_index[4:1], node_index[9:5], table_full[10], zero [15:11]
  output      logic [mahct_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned NW = $clog2(POOL_NODES);
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned MW = mahct_pkg::MAC_W;
  localparam logic [NW:0] POOL_LIMIT = (NW + 1)'(POOL_NODES);
  localparam logic [NW-1:0] LAST_NODE = NW'(POOL_NODES - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_HASH     = 4'd1;
  localparam logic [3:0] S_BKT      = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_INS_WR   = 4'd4;
  localparam logic [3:0] S_INS_LINK = 4'd5;
  localparam logic [3:0] S_WALK_RD  = 4'd6;
  localparam logic [3:0] S_WALK_CMP = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]                        state_q, state_d;
  logic [mahct_pkg::FUNC_W-1:0]      func_q, func_d;
  logic [MW-1:0]                     mac_q, mac_d;
  logic [mahct_pkg::TAG_W-1:0]       tag_q, tag_d;
  logic [BW-1:0]                     bkt_q, bkt_d;
  logic [NW-1:0]                     head_q, head_d;
  logic [NW-1:0]                     tail_q, tail_d;
  logic                              head_ok_q, head_ok_d;
  logic [NW-1:0]                     node_q, node_d;
  logic [NW-1:0]                     steps_q, steps_d;
  logic                              hit_q, hit_d;
  logic                              full_q, full_d;
  logic [POOL_NODES-1:0]             used_q, used_d;
  logic [BUCKETS-1:0]                bvalid_q, bvalid_d;
  logic                              out_valid_q, out_valid_d;
  logic [mahct_pkg::OUT_DATA_W-1:0]  out_data_q, out_data_d;

  logic                              in_beat;
  logic                              mod_start;
  logic                              mod_busy;
  logic [BW-1:0]                     mod_rem;
  logic                              addr_we;
  logic                              next_we;
  logic [NW-1:0]                     next_waddr;
  logic [NW-1:0]                     next_wdata;
  logic                              bkt_we;
  logic [2*NW-1:0]                   bkt_wdata;
  logic [MW-1:0]                     addr_rdata;
  logic [NW-1:0]                     next_rdata;
  logic [2*NW-1:0]                   bkt_rdata;
  logic [NW-1:0]                     rd_head;
  logic [31:0]                       bkt_ext;
  logic [31:0]                       node_ext;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // remainder unit for the bucket number
  mahct_mod #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .word_i  (s_axis_tdata_i[mahct_pkg::MAC_LSB + mahct_pkg::HASH_LSB +:
                             mahct_pkg::HASH_BITS]),
    .busy_o  (mod_busy),
    .rem_o   (mod_rem)
  );

  // node address store
  mahct_ram #(
    .WIDTH (MW),
    .DEPTH (POOL_NODES)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (node_q),
    .wdata_i (mac_q),
    .raddr_i (node_q),
    .rdata_o (addr_rdata)
  );

  // node link store
  mahct_ram #(
    .WIDTH (NW),
    .DEPTH (POOL_NODES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (node_q),
    .rdata_o (next_rdata)
  );

  // bucket head and tail store, head in the upper half
  mahct_ram #(
    .WIDTH (2 * NW),
    .DEPTH (BUCKETS)
  ) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_q),
    .wdata_i (bkt_wdata),
    .raddr_i (mod_rem),
    .rdata_o (bkt_rdata)
  );

  // a bucket not written since clear reads as empty
  assign rd_head = bvalid_q[bkt_q] ? bkt_rdata[2*NW-1:NW] : '0;

  assign bkt_ext  = 32'(bkt_q);
  assign node_ext = 32'(node_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    mac_d       = mac_q;
    tag_d       = tag_q;
    bkt_d       = bkt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    head_ok_d   = head_ok_q;
    node_d      = node_q;
    steps_d     = steps_q;
    hit_d       = hit_q;
    full_d      = full_q;
    used_d      = used_q;
    bvalid_d    = bvalid_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mod_start   = 1'b0;
    addr_we     = 1'b0;
    next_we     = 1'b0;
    next_waddr  = node_q;
    next_wdata  = '0;
    bkt_we      = 1'b0;
    bkt_wdata   = {(head_ok_q ? head_q : node_q), node_q};

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          func_d = s_axis_tdata_i[mahct_pkg::FUNC_LSB +: mahct_pkg::FUNC_W];
          mac_d  = s_axis_tdata_i[mahct_pkg::MAC_LSB +: MW];
          tag_d  = s_axis_tdata_i[mahct_pkg::TAG_LSB +: mahct_pkg::TAG_W];
          hit_d  = 1'b0;
          full_d = 1'b0;
          bkt_d  = '0;
          node_d = '0;
          case (func_d)
            mahct_pkg::FUNC_LOOKUP, mahct_pkg::FUNC_INSERT: begin
              mod_start = 1'b1;
              state_d   = S_HASH;
            end
            mahct_pkg::FUNC_CLEAR: begin
              used_d   = '0;
              bvalid_d = '0;
              state_d  = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (!mod_busy) begin
          bkt_d   = mod_rem;
          state_d = S_BKT;
        end
      end
      S_BKT: begin
        head_d    = rd_head;
        tail_d    = bkt_rdata[NW-1:0];
        head_ok_d = (rd_head != '0);
        steps_d   = '0;
        if (func_q == mahct_pkg::FUNC_LOOKUP) begin
          if (rd_head == '0 || {1'b0, rd_head} >= POOL_LIMIT) begin
            node_d  = '0;
            state_d = S_DONE;
          end else begin
            node_d  = rd_head;
            state_d = S_WALK_RD;
          end
        end else if (tag_q == '0) begin
          node_d  = '0;
          state_d = S_DONE;
        end else begin
          node_d  = NW'(1);
          state_d = S_SCAN;
        end
      end
      // lowest free node from 1 upward
      S_SCAN: begin
        if (!used_q[node_q]) begin
          state_d = S_INS_WR;
        end else if (node_q == LAST_NODE) begin
          full_d  = 1'b1;
          node_d  = '0;
          state_d = S_DONE;
        end else begin
          node_d = node_q + NW'(1);
        end
      end
      S_INS_WR: begin
        addr_we          = 1'b1;
        next_we          = 1'b1;
        bkt_we           = 1'b1;
        used_d[node_q]   = 1'b1;
        bvalid_d[bkt_q]  = 1'b1;
        if (head_ok_q && {1'b0, tail_q} < POOL_LIMIT) begin
          state_d = S_INS_LINK;
        end else begin
          state_d = S_DONE;
        end
      end
      // append to the old tail
      S_INS_LINK: begin
        next_we    = 1'b1;
        next_waddr = tail_q;
        next_wdata = node_q;
        state_d    = S_DONE;
      end
      S_WALK_RD: begin
        state_d = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (addr_rdata == mac_q) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else if (next_rdata == '0 || {1'b0, next_rdata} >= POOL_LIMIT ||
                     steps_q == LAST_NODE) begin
          node_d  = '0;
          state_d = S_DONE;
        end else begin
          node_d  = next_rdata;
          steps_d = steps_q + NW'(1);
          state_d = S_WALK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[mahct_pkg::HIT_BIT]  = hit_q;
          out_data_d[mahct_pkg::BKT_LSB +: mahct_pkg::BKT_W]   =
            bkt_ext[mahct_pkg::BKT_W-1:0];
          out_data_d[mahct_pkg::NODE_LSB +: mahct_pkg::NODE_W] =
            node_ext[mahct_pkg::NODE_W-1:0];
          out_data_d[mahct_pkg::FULL_BIT] = full_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      bvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      bvalid_q    <= bvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    mac_q      <= mac_d;
    tag_q      <= tag_d;
    bkt_q      <= bkt_d;
    head_q     <= head_d;
    tail_q     <= tail_d;
    head_ok_q  <= head_ok_d;
    node_q     <= node_d;
    steps_q    <= steps_d;
    hit_q      <= hit_d;
    full_q     <= full_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/mahct_checker.sv */
// mahct_checker: port-level assertions for the mac address chained hash table
// bound to the top level below
// depends on mahct_pkg
`default_nettype none

module mahct_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid_i,
  input wire logic                             s_axis_tready_o,
  input wire logic [mahct_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input wire logic                             m_axis_tvalid_o,
  input wire logic                             m_axis_tready_i,
  input wire logic [mahct_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic                          out_hit;
  logic                          out_full;
  logic [mahct_pkg::NODE_W-1:0]  out_node;
  logic [mahct_pkg::FUNC_W-1:0]  in_func;

  assign out_hit  = m_axis_tdata_o[mahct_pkg::HIT_BIT];
  assign out_full = m_axis_tdata_o[mahct_pkg::FULL_BIT];
  assign out_node = m_axis_tdata_o[mahct_pkg::NODE_LSB +: mahct_pkg::NODE_W];
  assign in_func  = s_axis_tdata_i[mahct_pkg::FUNC_LSB +: mahct_pkg::FUNC_W];

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // one beat in work at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a beat is in work");

  // a clear taken while no result is waiting answers with an all-zero result
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && in_func == mahct_pkg::FUNC_CLEAR
    && !m_axis_tvalid_o |=> ##1 m_axis_tvalid_o && m_axis_tdata_o == '0)
    else $error("clear result not zero");

  // a hit names a real node and is never a full report
  a_hit_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_hit |-> out_node != '0 && !out_full)
    else $error("hit with null node or full flag");

  // a full pool allocates nothing
  a_full_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_full |-> out_node == '0)
    else $error("full report with a node index");

endmodule

bind mac_address_chained_hash_table mahct_checker u_mahct_checker (.*);

`default_nettype wire
